// ----- src/mf3_pkg.sv -----
package mf3_pkg;

	localparam int PIX_W           = 8;
	localparam int WIN_SIZE        = 9;
	localparam int WIDTH_W         = 11;
	localparam int HEIGHT_W        = 13;
	localparam int CFG_DATA_W      = 13;
	localparam int ROW_W           = 12;
	localparam int MAX_HEIGHT      = 4096;
	localparam int RST_WIDTH       = 640;
	localparam int RST_HEIGHT      = 480;
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int DEF_OUT_DEPTH   = 8;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [WIN_SIZE-1:0][PIX_W-1:0] pix;
		logic                           last;
	} win_word_t;

endpackage

// ----- src/median_filter_3x3_stream.sv -----
// 3x3 median filter over a raster-order stream of 8-bit gray pixels.
// Input channel: drive pixel_in and push; a word is taken at a clock edge
// with push high and full low. Output channel: while empty is low,
// median_out and last_of_frame hold the oldest result; pop takes it.
// One result comes out for every pixel at column >= 2 and row >= 2, the
// median of the window centred one row up and one column left; border
// pixels give none. last_of_frame marks the final interior pixel.
// Configuration: cfg_we writes cfg_data into image_width (index 0) or
// image_height (index 1); write only while the block is idle.
// Throughput: one pixel per cycle while full is low, set by the line
// store port (one read and one write per store each cycle) and the
// pipelined median network. An accepted pixel passes line store read,
// window shift, column sort and rank merge before the output fifo.
// When pop is held low, results collect in the output fifo and in the
// window queue; once those fill, full goes high until pop resumes.
// Reset clears counters, window, queues and restores 640 x 480; the line
// stores hold no reset value and are rewritten by the first two rows.
module median_filter_3x3_stream #(
	parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
	parameter int QUEUE_DEPTH = mf3_pkg::DEF_QUEUE_DEPTH,
	parameter int OUT_DEPTH   = mf3_pkg::DEF_OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  mf3_pkg::pix_t                  pixel_in,
	input  logic                           pop,
	output logic                           empty,
	output mf3_pkg::pix_t                  median_out,
	output logic                           last_of_frame,
	input  logic                           cfg_we,
	input  mf3_pkg::cfg_reg_t              cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mf3_pkg::*;

	localparam int QCW = $clog2(QUEUE_DEPTH+1);

	logic           q_push, q_pop, q_empty, q_full;
	logic [QCW-1:0] q_count;
	win_word_t      q_wword, q_rword;

	mf3_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel_in  (pixel_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.q_push    (q_push),
		.q_word    (q_wword)
	);

	mf3_fifo #(
		.WIDTH ($bits(win_word_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_win_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wword),
		.pop    (q_pop),
		.rdata  (q_rword),
		.empty  (q_empty),
		.full   (q_full),
		.count  (q_count)
	);

	mf3_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_word        (q_rword),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.median_out    (median_out),
		.last_of_frame (last_of_frame)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> full)
		else $error("input open while window queue is full");

endmodule

// ----- src/mf3_fifo.sv -----
module mf3_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word pushed into full fifo");

endmodule

// ----- src/mf3_front.sv -----
module mf3_front #(
	parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
	parameter int QUEUE_DEPTH = mf3_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  mf3_pkg::pix_t                      pixel_in,
	input  logic                               cfg_we,
	input  mf3_pkg::cfg_reg_t                  cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
	output logic                               q_push,
	output mf3_pkg::win_word_t                 q_word
);
	import mf3_pkg::*;

	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW  = (XW + 1 > WIDTH_W) ? XW + 1 : WIDTH_W;
	localparam int QCW = $clog2(QUEUE_DEPTH+1);

	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	logic [WIDTH_W-1:0]             width_q;
	logic [HEIGHT_W-1:0]            height_q;
	logic [XW-1:0]                  col_q;
	logic [ROW_W-1:0]               row_q;
	logic [WIN_SIZE-1:0][PIX_W-1:0] win_q, win_next;

	logic          v_s1, emit_s1, last_s1;
	pix_t          up_s1, mid_s1, p_s1;
	logic [XW-1:0] x_s1;

	logic                in_acc;
	logic [CW-1:0]       w_ext, w_eff, w_m1;
	logic [HEIGHT_W-1:0] h_eff, h_m1;
	logic                row_end, frame_end, emit;

	assign in_acc = push && !full;
	assign full   = ((QCW+1)'(q_count) + (QCW+1)'(v_s1)) >= (QCW+1)'(QUEUE_DEPTH);

	always_comb begin
		w_ext = CW'(width_q);
		if (w_ext < CW'(3)) begin
			w_eff = CW'(3);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		w_m1 = w_eff - 1'b1;
		if (height_q < HEIGHT_W'(3)) begin
			h_eff = HEIGHT_W'(3);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		h_m1      = h_eff - 1'b1;
		row_end   = CW'(col_q) >= w_m1;
		frame_end = row_end && (HEIGHT_W'(row_q) >= h_m1);
		emit      = (col_q >= XW'(2)) && (row_q >= ROW_W'(2));
	end

	always_comb begin
		win_next = win_q;
		for (int r = 0; r < 3; r++) begin
			win_next[r*3]   = win_q[r*3+1];
			win_next[r*3+1] = win_q[r*3+2];
		end
		win_next[2] = up_s1;
		win_next[5] = mid_s1;
		win_next[8] = p_s1;
	end

	assign q_push      = v_s1 && emit_s1;
	assign q_word.pix  = win_next;
	assign q_word.last = last_s1;

	// upper store takes the old middle word in the cycle after the read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1              <= upper_mem[col_q];
			mid_s1             <= middle_mem[col_q];
			middle_mem[col_q]  <= pixel_in;
			p_s1               <= pixel_in;
			x_s1               <= col_q;
		end
		if (v_s1) begin
			upper_mem[x_s1] <= mid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(RST_WIDTH);
			height_q <= HEIGHT_W'(RST_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '0;
			v_s1     <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
					default:          width_q  <= width_q;
				endcase
			end
			v_s1 <= in_acc;
			if (in_acc) begin
				emit_s1 <= emit;
				last_s1 <= frame_end;
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (v_s1) begin
				win_q <= win_next;
			end
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= XW'(MAX_WIDTH-1))
		else $error("column counter out of range");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted pixel lost before window update");

endmodule

// ----- src/mf3_back.sv -----
module mf3_back #(
	parameter int OUT_DEPTH = mf3_pkg::DEF_OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  mf3_pkg::win_word_t q_word,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output mf3_pkg::pix_t      median_out,
	output logic               last_of_frame
);
	import mf3_pkg::*;

	localparam int OCW = $clog2(OUT_DEPTH+1);

	typedef logic [2:0][PIX_W-1:0] pix3_t;

	function automatic pix3_t sort3(input pix_t a, input pix_t b, input pix_t c);
		pix_t  lo1, hi1, m;
		pix3_t s;
		lo1  = (a < b) ? a : b;
		hi1  = (a < b) ? b : a;
		m    = (hi1 < c) ? hi1 : c;
		s[2] = (hi1 < c) ? c : hi1;
		s[0] = (lo1 < m) ? lo1 : m;
		s[1] = (lo1 < m) ? m : lo1;
		return s;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		pix3_t s;
		s = sort3(a, b, c);
		return s[1];
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		pix_t t;
		t = (a > b) ? a : b;
		return (t > c) ? t : c;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		pix_t t;
		t = (a < b) ? a : b;
		return (t < c) ? t : c;
	endfunction

	pix3_t         col_s1 [3];
	logic          v_s1, last_s1;
	pix_t          lo_s2, mid_s2, hi_s2;
	logic          v_s2, last_s2;
	pix_t          fin_med;
	logic [OCW-1:0] o_count;
	logic          o_full;
	logic [PIX_W:0] o_rdata;

	assign q_pop = !q_empty &&
		(((OCW+1)'(o_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2)) < (OCW+1)'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int c = 0; c < 3; c++) begin
				col_s1[c] <= sort3(q_word.pix[c], q_word.pix[3+c], q_word.pix[6+c]);
			end
			last_s1 <= q_word.last;
		end
		if (v_s1) begin
			lo_s2   <= max3(col_s1[0][0], col_s1[1][0], col_s1[2][0]);
			mid_s2  <= med3(col_s1[0][1], col_s1[1][1], col_s1[2][1]);
			hi_s2   <= min3(col_s1[0][2], col_s1[1][2], col_s1[2][2]);
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
		end
	end

	assign fin_med = med3(lo_s2, mid_s2, hi_s2);

	mf3_fifo #(
		.WIDTH (PIX_W + 1),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  ({fin_med, last_s2}),
		.pop    (pop),
		.rdata  (o_rdata),
		.empty  (empty),
		.full   (o_full),
		.count  (o_count)
	);

	assign median_out    = o_rdata[PIX_W:1];
	assign last_of_frame = o_rdata[0];

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		((OCW+1)'(o_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2)) <= (OCW+1)'(OUT_DEPTH))
		else $error("result words in flight exceed output room");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !o_full)
		else $error("median word arrived at full output fifo");

endmodule
